// File: rtl/grg_pkg.sv
`default_nettype none
package grg_pkg;

  localparam int RAMP_ENTRIES = 256;
  localparam int PIVOT        = RAMP_ENTRIES / 2 - 1;
  localparam int HALF         = RAMP_ENTRIES / 2;

  localparam int IDX_W    = 8;
  localparam int GAMMA_W  = 11;
  localparam int CONTR_W  = 10;
  localparam int BRIGHT_W = 9;
  localparam int VAL_W    = 16;

  localparam int FRAC      = 24;
  localparam int MANT_W    = 31;
  localparam int LOG_STEPS = 24;
  localparam int MAG_W     = 37;
  localparam int DIV_STEPS = MAG_W;
  localparam int REM_W     = GAMMA_W;
  localparam int E_W       = 40;

  localparam logic [GAMMA_W-1:0] GAMMA_LO   = 11'd26;
  localparam logic [GAMMA_W-1:0] GAMMA_HI   = 11'd1024;
  localparam logic [GAMMA_W-1:0] GAMMA_UNIT = 11'd256;
  localparam logic [CONTR_W-1:0] CONTR_LO   = 10'd26;
  localparam logic [CONTR_W-1:0] CONTR_HI   = 10'd768;
  localparam logic [CONTR_W-1:0] CONTR_RST  = 10'd256;
  localparam logic signed [BRIGHT_W-1:0] BRIGHT_LO = -9'sd205;
  localparam logic signed [BRIGHT_W-1:0] BRIGHT_HI = 9'sd205;

  localparam logic [1:0] REG_GAMMA    = 2'd0;
  localparam logic [1:0] REG_CONTRAST = 2'd1;
  localparam logic [1:0] REG_BRIGHT   = 2'd2;

  typedef struct packed {
    logic               byp;
    logic signed [17:0] bval;
  } grg_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q.30 for k = 1..24, packed lowest k first
  function automatic logic [LOG_STEPS*MANT_W-1:0] build_roots();
    logic [63:0]                  r;
    logic [LOG_STEPS*MANT_W-1:0] tab;
    r = isqrt64(64'd2 << 60);
    tab = '0;
    for (int k = 0; k < LOG_STEPS; k++) begin
      if (k > 0) r = isqrt64(r << 30);
      tab[k*MANT_W +: MANT_W] = r[MANT_W-1:0];
    end
    return tab;
  endfunction

  function automatic logic [27:0] log2_fs();
    logic [63:0] m;
    logic [23:0] fr;
    m  = 64'(RAMP_ENTRIES - 1) << 23;
    fr = '0;
    for (int k = 0; k < FRAC; k++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m     = m >> 1;
        fr[0] = 1'b1;
      end
    end
    return (28'd7 << FRAC) + 28'(fr);
  endfunction

  localparam logic [LOG_STEPS*MANT_W-1:0] ROOT_PK = build_roots();
  localparam logic [27:0] LF = log2_fs();
  // 8 + log2(255) in Q.24
  localparam logic [30:0] LOG_OFS = (31'd8 << FRAC) + 31'(LF);

endpackage
`default_nettype wire

// File: rtl/grg_cfg.sv
`default_nettype none
module grg_cfg (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_psel,
  input  wire logic                    cfg_penable,
  input  wire logic                    cfg_pwrite,
  input  wire logic [3:0]              cfg_paddr,
  input  wire logic [31:0]             cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output logic [grg_pkg::GAMMA_W-1:0]  gamma,
  output logic [grg_pkg::CONTR_W-1:0]  contrast,
  output logic signed [grg_pkg::BRIGHT_W-1:0] bright
);

  logic [grg_pkg::GAMMA_W-1:0]         gamma_r, gamma_nxt;
  logic [grg_pkg::CONTR_W-1:0]         contr_r, contr_nxt;
  logic signed [grg_pkg::BRIGHT_W-1:0] bright_r, bright_nxt;
  logic                                wr;
  logic signed [grg_pkg::BRIGHT_W-1:0] bw;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign bw = $signed(cfg_pwdata[grg_pkg::BRIGHT_W-1:0]);

  always_comb begin
    gamma_nxt  = gamma_r;
    contr_nxt  = contr_r;
    bright_nxt = bright_r;
    if (wr) begin
      case (cfg_paddr[3:2])
        grg_pkg::REG_GAMMA: begin
          gamma_nxt = cfg_pwdata[grg_pkg::GAMMA_W-1:0];
          if (gamma_nxt < grg_pkg::GAMMA_LO) gamma_nxt = grg_pkg::GAMMA_LO;
          if (gamma_nxt > grg_pkg::GAMMA_HI) gamma_nxt = grg_pkg::GAMMA_HI;
        end
        grg_pkg::REG_CONTRAST: begin
          contr_nxt = cfg_pwdata[grg_pkg::CONTR_W-1:0];
          if (contr_nxt < grg_pkg::CONTR_LO) contr_nxt = grg_pkg::CONTR_LO;
          if (contr_nxt > grg_pkg::CONTR_HI) contr_nxt = grg_pkg::CONTR_HI;
        end
        grg_pkg::REG_BRIGHT: begin
          bright_nxt = bw;
          if (bw < grg_pkg::BRIGHT_LO) bright_nxt = grg_pkg::BRIGHT_LO;
          if (bw > grg_pkg::BRIGHT_HI) bright_nxt = grg_pkg::BRIGHT_HI;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r  <= grg_pkg::GAMMA_UNIT;
      contr_r  <= grg_pkg::CONTR_RST;
      bright_r <= '0;
    end else begin
      gamma_r  <= gamma_nxt;
      contr_r  <= contr_nxt;
      bright_r <= bright_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      grg_pkg::REG_GAMMA:    cfg_prdata = 32'(gamma_r);
      grg_pkg::REG_CONTRAST: cfg_prdata = 32'(contr_r);
      grg_pkg::REG_BRIGHT:   cfg_prdata = {{(32-grg_pkg::BRIGHT_W){bright_r[8]}}, bright_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign gamma    = gamma_r;
  assign contrast = contr_r;
  assign bright   = bright_r;

endmodule
`default_nettype wire

// File: rtl/grg_log.sv
`default_nettype none
module grg_log (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [grg_pkg::IDX_W-1:0]  idx,
  input  wire logic [grg_pkg::GAMMA_W-1:0] gamma,
  input  wire logic [grg_pkg::CONTR_W-1:0] contrast,
  output logic                            out_valid,
  output grg_pkg::grg_side_t              out_side,
  output logic                            out_neg,
  output logic [grg_pkg::MAG_W-1:0]       out_mag
);

  localparam int N = grg_pkg::LOG_STEPS;

  // contrast stage
  logic               vc_r;
  logic signed [18:0] v8_r;
  logic signed [18:0] a, b, v8_nxt;

  always_comb begin
    a = $signed({{10{1'b0}}, idx}) - $signed(19'(grg_pkg::PIVOT));
    b = $signed({{(19-grg_pkg::CONTR_W){1'b0}}, contrast});
    v8_nxt = a * b + $signed(19'(grg_pkg::PIVOT * 256));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) v8_r <= v8_nxt;
  end

  // normalise, then one squaring per stage
  logic                  lv_r   [0:N];
  logic [30:0]           lm_r   [0:N];
  logic [23:0]           lf_r   [0:N];
  logic [4:0]            ln_r   [0:N];
  grg_pkg::grg_side_t    ls_r   [0:N];
  logic [30:0]           lm_nxt [0:N];
  logic [23:0]           lf_nxt [0:N];

  logic                  pos;
  logic [4:0]            n0;
  logic [30:0]           m0;
  grg_pkg::grg_side_t    s0;
  logic                  lin;

  always_comb begin
    pos = !v8_r[18] && (|v8_r);
    lin = (gamma == grg_pkg::GAMMA_UNIT);
    n0  = '0;
    for (int i = 0; i < 17; i++) begin
      if (v8_r[i]) n0 = 5'(i);
    end
    m0 = 31'(v8_r[16:0]) << (5'd30 - n0);
    if (!pos) begin
      n0 = '0;
      m0 = 31'd1 << 30;
    end
    s0.byp  = lin || !pos;
    s0.bval = lin ? v8_r[17:0] : '0;
  end

  logic [61:0] sq [0:N-1];
  logic [31:0] t  [0:N-1];

  always_comb begin
    lm_nxt[0] = m0;
    lf_nxt[0] = '0;
    for (int k = 0; k < N; k++) begin
      sq[k] = 62'(lm_r[k]) * 62'(lm_r[k]);
      t[k]  = sq[k][61:30];
      if (t[k][31]) begin
        lm_nxt[k+1] = t[k][31:1];
        lf_nxt[k+1] = {lf_r[k][22:0], 1'b1};
      end else begin
        lm_nxt[k+1] = t[k][30:0];
        lf_nxt[k+1] = {lf_r[k][22:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) lv_r[k] <= 1'b0;
    end else if (en) begin
      lv_r[0] <= vc_r;
      for (int k = 0; k < N; k++) lv_r[k+1] <= lv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N; k++) begin
        lm_r[k] <= lm_nxt[k];
        lf_r[k] <= lf_nxt[k];
      end
      ln_r[0] <= n0;
      ls_r[0] <= s0;
      for (int k = 0; k < N; k++) begin
        ln_r[k+1] <= ln_r[k];
        ls_r[k+1] <= ls_r[k];
      end
    end
  end

  // remove the 8 fraction bits and log2(255), scale by 256
  logic signed [30:0] l;
  logic [30:0]        absl;

  always_comb begin
    l    = $signed({2'b00, ln_r[N], lf_r[N]}) - $signed(grg_pkg::LOG_OFS);
    absl = l[30] ? 31'(-l) : 31'(l);
  end

  logic                      nv_r;
  grg_pkg::grg_side_t        ns_r;
  logic                      nneg_r;
  logic [grg_pkg::MAG_W-1:0] nmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r <= 1'b0;
    else if (en) nv_r <= lv_r[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ns_r   <= ls_r[N];
      nneg_r <= l[30];
      nmag_r <= {absl[28:0], 8'b0};
    end
  end

  assign out_valid = nv_r;
  assign out_side  = ns_r;
  assign out_neg   = nneg_r;
  assign out_mag   = nmag_r;

endmodule
`default_nettype wire

// File: rtl/grg_div.sv
`default_nettype none
module grg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire grg_pkg::grg_side_t          in_side,
  input  wire logic                        in_neg,
  input  wire logic [grg_pkg::MAG_W-1:0]   in_mag,
  input  wire logic [grg_pkg::GAMMA_W-1:0] gamma,
  output logic                             out_valid,
  output grg_pkg::grg_side_t               out_side,
  output logic signed [grg_pkg::E_W-1:0]   out_e
);

  localparam int N  = grg_pkg::DIV_STEPS;
  localparam int MW = grg_pkg::MAG_W;
  localparam int RW = grg_pkg::REM_W;

  // one quotient bit per stage; dividend bits shift out as quotient bits shift in
  logic               dv_r  [0:N];
  logic [MW-1:0]      dq_r  [0:N];
  logic [RW-1:0]      dr_r  [0:N];
  logic               dn_r  [0:N];
  grg_pkg::grg_side_t ds_r  [0:N];
  logic [MW-1:0]      dq_nxt[0:N];
  logic [RW-1:0]      dr_nxt[0:N];
  logic [RW:0]        tr    [0:N-1];

  always_comb begin
    dq_nxt[0] = in_mag;
    dr_nxt[0] = '0;
    for (int k = 0; k < N; k++) begin
      tr[k] = {dr_r[k], dq_r[k][MW-1]};
      if (tr[k] >= {1'b0, gamma}) begin
        dr_nxt[k+1] = RW'(tr[k] - {1'b0, gamma});
        dq_nxt[k+1] = {dq_r[k][MW-2:0], 1'b1};
      end else begin
        dr_nxt[k+1] = tr[k][RW-1:0];
        dq_nxt[k+1] = {dq_r[k][MW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_valid;
      for (int k = 0; k < N; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N; k++) begin
        dq_r[k] <= dq_nxt[k];
        dr_r[k] <= dr_nxt[k];
      end
      dn_r[0] <= in_neg;
      ds_r[0] <= in_side;
      for (int k = 0; k < N; k++) begin
        dn_r[k+1] <= dn_r[k];
        ds_r[k+1] <= ds_r[k];
      end
    end
  end

  // floor division: round a negative quotient away from zero when inexact
  logic [MW:0]                    qa;
  logic [MW:0]                    mq;
  logic signed [grg_pkg::E_W-1:0] e_nxt;

  always_comb begin
    qa    = {1'b0, dq_r[N]} + (MW+1)'(|dr_r[N]);
    mq    = dn_r[N] ? (MW+1)'(-qa) : {1'b0, dq_r[N]};
    e_nxt = $signed({{(grg_pkg::E_W-MW-1){mq[MW]}}, mq})
          + $signed(grg_pkg::E_W'(grg_pkg::LOG_OFS));
  end

  logic                           ev_r;
  grg_pkg::grg_side_t             es_r;
  logic signed [grg_pkg::E_W-1:0] e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ev_r <= 1'b0;
    else if (en) ev_r <= dv_r[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      es_r <= ds_r[N];
      e_r  <= e_nxt;
    end
  end

  assign out_valid = ev_r;
  assign out_side  = es_r;
  assign out_e     = e_r;

endmodule
`default_nettype wire

// File: rtl/grg_exp.sv
`default_nettype none
module grg_exp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire grg_pkg::grg_side_t                in_side,
  input  wire logic signed [grg_pkg::E_W-1:0]    in_e,
  input  wire logic signed [grg_pkg::BRIGHT_W-1:0] bright,
  output logic                                   out_valid,
  output logic [grg_pkg::VAL_W-1:0]              out_value,
  output logic                                   out_clip
);

  localparam int N  = grg_pkg::LOG_STEPS;
  localparam int FR = grg_pkg::FRAC;

  typedef struct packed {
    grg_pkg::grg_side_t side;
    logic               lo;
    logic               hi;
    logic [6:0]         ip;
    logic [FR-1:0]      f;
  } exp_ctl_t;

  logic        xv_r  [0:N];
  logic [30:0] xr_r  [0:N];
  exp_ctl_t    xc_r  [0:N];
  logic [30:0] xr_nxt[0:N];
  logic [61:0] pr    [0:N-1];
  exp_ctl_t    c0;
  logic signed [15:0] ipw;

  always_comb begin
    ipw     = in_e[grg_pkg::E_W-1:FR];
    c0.side = in_side;
    c0.lo   = ipw < -16'sd40;
    c0.hi   = ipw > 16'sd39;
    c0.ip   = ipw[6:0];
    c0.f    = in_e[FR-1:0];
  end

  // multiply in 2^(2^-k) for each set fraction bit, most significant first
  always_comb begin
    xr_nxt[0] = 31'd1 << 30;
    for (int k = 0; k < N; k++) begin
      pr[k] = 62'(xr_r[k]) * 62'(grg_pkg::ROOT_PK[k*grg_pkg::MANT_W +: grg_pkg::MANT_W]);
      if (xc_r[k].f[FR-1-k]) xr_nxt[k+1] = pr[k][60:30];
      else xr_nxt[k+1] = xr_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) xv_r[k] <= 1'b0;
    end else if (en) begin
      xv_r[0] <= in_valid;
      for (int k = 0; k < N; k++) xv_r[k+1] <= xv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N; k++) xr_r[k] <= xr_nxt[k];
      xc_r[0] <= c0;
      for (int k = 0; k < N; k++) xc_r[k+1] <= xc_r[k];
    end
  end

  // integer part of the exponent: one right shift of r*2^9 by 39-ip
  logic [6:0]  sh;
  logic [39:0] shv;
  logic [40:0] val_nxt;

  always_comb begin
    sh  = 7'd39 - xc_r[N].ip;
    shv = {xr_r[N], 9'b0} >> sh;
    if (xc_r[N].hi) val_nxt = 41'd1 << 40;
    else if (xc_r[N].lo) val_nxt = '0;
    else val_nxt = {1'b0, shv};
  end

  logic               sv_r;
  grg_pkg::grg_side_t ss_r;
  logic [40:0]        val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else if (en) sv_r <= xv_r[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ss_r  <= xc_r[N].side;
      val_r <= val_nxt;
    end
  end

  // add brightness and saturate
  logic signed [42:0] total;
  logic [15:0]        ov_nxt;
  logic               oc_nxt;

  always_comb begin
    total = ss_r.byp ? {{25{ss_r.bval[17]}}, ss_r.bval} : $signed({2'b00, val_r});
    total = total + $signed({{27{bright[8]}}, bright, 7'b0});
    if (total[42]) begin
      ov_nxt = '0;
      oc_nxt = 1'b1;
    end else if (|total[41:16]) begin
      ov_nxt = 16'hFFFF;
      oc_nxt = 1'b1;
    end else begin
      ov_nxt = total[15:0];
      oc_nxt = 1'b0;
    end
  end

  logic        ovl_r;
  logic [15:0] oval_r;
  logic        oclip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ovl_r <= 1'b0;
    else if (en) ovl_r <= sv_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      oval_r  <= ov_nxt;
      oclip_r <= oc_nxt;
    end
  end

  assign out_valid = ovl_r;
  assign out_value = oval_r;
  assign out_clip  = oclip_r;

endmodule
`default_nettype wire

// File: rtl/gamma_ramp_generator_top.sv
// Throughput: one word per cycle unless a result is held at the output; the pipeline is
// 24 log2 squaring stages, a 37-stage restoring divider and 24 exp2 multiply stages,
// and it advances as one whole. Reset (rst_n, synchronous, active low) empties the
// pipeline and sets gamma and contrast to 1.0 and brightness to 0.
`default_nettype none
module gamma_ramp_generator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ramp_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] ramp_value
  output logic [0:0]       out_tuser,  // [0] was_clipped
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [grg_pkg::GAMMA_W-1:0]         gamma;
  logic [grg_pkg::CONTR_W-1:0]         contrast;
  logic signed [grg_pkg::BRIGHT_W-1:0] bright;
  logic                                en;

  logic                      l_valid;
  grg_pkg::grg_side_t        l_side;
  logic                      l_neg;
  logic [grg_pkg::MAG_W-1:0] l_mag;

  logic                           d_valid;
  grg_pkg::grg_side_t             d_side;
  logic signed [grg_pkg::E_W-1:0] d_e;

  logic clip;

  // advance the whole pipe unless a result is held at the output
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  grg_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .gamma, .contrast, .bright
  );

  grg_log u_log (
    .clk, .rst_n, .en,
    .in_valid  (in_tvalid),
    .idx       (in_tdata),
    .gamma, .contrast,
    .out_valid (l_valid),
    .out_side  (l_side),
    .out_neg   (l_neg),
    .out_mag   (l_mag)
  );

  grg_div u_div (
    .clk, .rst_n, .en,
    .in_valid  (l_valid),
    .in_side   (l_side),
    .in_neg    (l_neg),
    .in_mag    (l_mag),
    .gamma,
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_e     (d_e)
  );

  grg_exp u_exp (
    .clk, .rst_n, .en,
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_e      (d_e),
    .bright,
    .out_valid (out_tvalid),
    .out_value (out_tdata),
    .out_clip  (clip)
  );

  assign out_tuser = clip;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [grg_pkg::VAL_W-1:0] value;
    logic                      clipped;
  } ramp_word_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [grg_pkg::IDX_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [grg_pkg::VAL_W-1:0] out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [3:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  logic [grg_pkg::IDX_W-1:0] index_q[$];
  ramp_word_t        ramp_q[$];
  longint            gamma_cur = 256;
  longint            contrast_cur = 256;
  longint            bright_cur = 0;
  longint unsigned   root_q30[grg_pkg::FRAC];
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;
  int                idle_pct = 10;
  int                mismatches = 0;
  int                cycles = 0;

  gamma_ramp_generator_top DUT (.*);

  always #4 clk = ~clk;

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint log2_fix(longint unsigned x);
    int n;
    longint unsigned m, fr;
    n = 0;
    fr = 0;
    while (n < 63 && (x >> (n + 1)) != 0) n++;
    m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
    for (int k = 0; k < grg_pkg::FRAC; k++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr = fr | 1;
      end
    end
    return longint'(n) * (longint'(1) << grg_pkg::FRAC) + longint'(fr);
  endfunction

  function automatic longint unsigned exp2_fix(longint e);
    longint lim, ip;
    longint unsigned u, f, r;
    lim = longint'(40) << grg_pkg::FRAC;
    if (e < -lim) return 0;
    if (e >= lim) return 64'd1 << 40;
    u = longint'(e + (longint'(64) << grg_pkg::FRAC));
    ip = longint'(u >> grg_pkg::FRAC) - 64;
    f = u & ((64'd1 << grg_pkg::FRAC) - 1);
    r = 64'd1 << 30;
    for (int k = 0; k < grg_pkg::FRAC; k++)
      if ((f >> (grg_pkg::FRAC - 1 - k)) & 1) r = (r * root_q30[k]) >> 30;
    if (ip >= 30) return r << (ip - 30);
    if (30 - ip >= 63) return 0;
    return r >> (30 - ip);
  endfunction

  function automatic ramp_word_t ramp_entry(logic [grg_pkg::IDX_W-1:0] idx);
    longint v8, total, lf, l, num, m;
    ramp_word_t w;
    v8 = (longint'(idx) - grg_pkg::PIVOT) * contrast_cur + grg_pkg::PIVOT * 256;
    if (gamma_cur == 256) total = v8;
    else if (v8 <= 0) total = 0;
    else begin
      lf = log2_fix(grg_pkg::RAMP_ENTRIES - 1);
      l = log2_fix(v8) - (longint'(8) << grg_pkg::FRAC) - lf;
      num = l * 256;
      // floor division for negative exponents
      if (num >= 0) m = num / gamma_cur;
      else m = -((-num + gamma_cur - 1) / gamma_cur);
      total = longint'(exp2_fix(lf + m + (longint'(8) << grg_pkg::FRAC)));
    end
    total += bright_cur * grg_pkg::HALF;
    if (total < 0) w = '{value: '0, clipped: 1'b1};
    else if (total > 65535) w = '{value: 16'hFFFF, clipped: 1'b1};
    else w = '{value: total[15:0], clipped: 1'b0};
    return w;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) ramp_q.push_back(ramp_entry(in_tdata));
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (index_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            in_gap = $urandom_range(0, 15);
            in_tvalid <= 1'b0;
          end else begin
            in_tvalid <= 1'b1;
            in_tdata <= index_q.pop_front();
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    ramp_word_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (ramp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: value %0d clip %0b",
                                         out_tdata, out_tuser[0]);
        end else begin
          want = ramp_q.pop_front();
          if (out_tdata !== want.value || out_tuser[0] !== want.clipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0b, got %0d/%0b",
                       want.value, want.clipped, out_tdata, out_tuser[0]);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_gap = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[gamma_ramp_generator_top] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (index_q.size() != 0 || in_tvalid || ramp_q.size() != 0);
  endtask

  task automatic reg_write(logic [1:0] sel, logic [31:0] data);
    longint v;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (sel)
      grg_pkg::REG_GAMMA: begin
        v = data & 32'h7FF;
        gamma_cur = (v < 26) ? 26 : (v > 1024) ? 1024 : v;
      end
      grg_pkg::REG_CONTRAST: begin
        v = data & 32'h3FF;
        contrast_cur = (v < 26) ? 26 : (v > 768) ? 768 : v;
      end
      grg_pkg::REG_BRIGHT: begin
        v = data & 32'h1FF;
        if (v >= 256) v -= 512;
        bright_cur = (v < -205) ? -205 : (v > 205) ? 205 : v;
      end
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] g, logic [31:0] c, logic [31:0] b);
    reg_write(grg_pkg::REG_GAMMA, g);
    reg_write(grg_pkg::REG_CONTRAST, c);
    reg_write(grg_pkg::REG_BRIGHT, b);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) index_q.push_back(grg_pkg::IDX_W'($urandom));
  endtask

  initial begin
    root_q30[0] = sqrt_floor(64'd2 << 60);
    for (int k = 1; k < grg_pkg::FRAC; k++)
      root_q30[k] = sqrt_floor(root_q30[k-1] << 30);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: linear path
    index_q = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255, 8'hAA, 8'h55};
    wait_drained();
    // extremes: low gamma clips at the top, high contrast gives a non-positive base
    set_all(32'd26, 32'd768, 32'h1FF & -205);
    index_q = '{8'd0, 8'd40, 8'd127, 8'd200, 8'd255};
    wait_drained();
    set_all(32'd1024, 32'd26, 32'd205);
    index_q = '{8'd0, 8'd1, 8'd128, 8'd255};
    wait_drained();
    // out-of-range writes saturate; an unknown register is ignored
    set_all(32'h7FF, 32'd0, 32'h0FF);
    reg_write(2'd3, 32'hFFFF_FFFF);
    index_q = '{8'd0, 8'd64, 8'd255};
    wait_drained();
    set_all(32'd0, 32'h3FF, 32'h100);
    index_q = '{8'd0, 8'd127, 8'd255};
    wait_drained();

    for (int p = 0; p < 11; p++) begin
      case ($urandom_range(0, 3))
        0: set_all($urandom, $urandom, $urandom);
        1: set_all(32'd256, $urandom_range(26, 768), $urandom);
        default: set_all($urandom_range(26, 1024), $urandom_range(26, 768),
                         32'h1FF & $urandom_range(0, 410) - 205);
      endcase
      idle_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
      if (p == 4) begin
        @(negedge clk);
        hold_req = 1'b1;
      end
      if (p == 10) quiet = 1'b1;
      // the long hold phase offers more words than the pipe can take
      push_random((p == 4) ? 200 : 53);
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && ramp_q.size() == 0) begin
      $display("[gamma_ramp_generator_top] OK");
    end else begin
      $display("[gamma_ramp_generator_top] ERROR");
    end
    $finish;
  end

endmodule
